// ===== hdl/char_lcd_command_text_sequencer_unit_defines.svh =====
// Assertion macros used by the LCD sequencer top level.
`ifndef CHAR_LCD_COMMAND_TEXT_SEQUENCER_UNIT_DEFINES_SVH
`define CHAR_LCD_COMMAND_TEXT_SEQUENCER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, clocked on clk, off during reset.
`define LCD_SEQ_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lcd_seq assertion failed");
// Next-cycle implication, clocked on clk, off during reset.
`define LCD_SEQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lcd_seq assertion failed");
`else
`define LCD_SEQ_ASSERT(lbl, ante, cons)
`define LCD_SEQ_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hdl/lcd_seq_pkg.sv =====
// Types, op codes, timing and command constants of the LCD sequencer.
package lcd_seq_pkg;

  localparam int DISPLAY_CHARS_DEF = 16;

  localparam int HOLD_W = 26;
  localparam int IDX_W  = 4;

  typedef logic [HOLD_W-1:0] hold_t;
  typedef logic [IDX_W-1:0]  idx_t;

  // Phase hold times in microseconds
  localparam hold_t T_ENABLE  = 26'd1;
  localparam hold_t T_SLOW    = 26'd1650;
  localparam hold_t T_INSTR   = 26'd40;
  localparam hold_t T_DATA    = 26'd45;
  localparam hold_t T_POWERUP = 26'd30000;
  localparam int    US_PER_MS = 1000;
  localparam int    DELAY_RESET_MS = 500;

  localparam logic [7:0] WRAP_INDEX   = 8'd7;
  localparam logic [7:0] NEWLINE_CHAR = 8'd10;
  localparam logic [6:0] ROW1_OFFSET  = 7'd40;

  // Fixed instruction bytes
  localparam logic [7:0] CMD_CLEAR        = 8'h01;
  localparam logic [7:0] CMD_HOME         = 8'h02;
  localparam logic [7:0] CMD_ENTRY        = 8'h04;
  localparam logic [7:0] CMD_DISPLAY      = 8'h08;
  localparam logic [7:0] CMD_SHIFT        = 8'h10;
  localparam logic [7:0] CMD_FUNCTION     = 8'h20;
  localparam logic [7:0] CMD_CGRAM        = 8'h40;
  localparam logic [7:0] CMD_DDRAM        = 8'h80;
  localparam logic [7:0] CMD_FUNC_2LINE   = 8'h38;
  localparam logic [7:0] CMD_FUNC_1LINE   = 8'h30;
  localparam logic [7:0] CMD_DISP_ON_CUR  = 8'h0E;
  localparam logic [7:0] CMD_ENTRY_INC    = 8'h06;
  localparam logic [7:0] CMD_SHIFT_LEFT   = 8'h18;
  localparam logic [7:0] CMD_CURSOR_MID   = 8'h87;
  localparam logic [7:0] CMD_CURSOR_ROW1  = 8'hA8;

  typedef enum logic [3:0] {
    OP_INIT       = 4'd0,
    OP_CLEAR      = 4'd1,
    OP_HOME       = 4'd2,
    OP_ENTRY      = 4'd3,
    OP_DISPLAY    = 4'd4,
    OP_SHIFT      = 4'd5,
    OP_FUNCTION   = 4'd6,
    OP_CGRAM      = 4'd7,
    OP_DDRAM      = 4'd8,
    OP_CHAR       = 4'd9,
    OP_CURSOR     = 4'd10,
    OP_TEXT_START = 4'd11,
    OP_TEXT_CHAR  = 4'd12
  } op_t;

  // Phase sequence shape of one request
  typedef enum logic [2:0] {
    K_NONE,          // no phases
    K_WRITE,         // one bus write
    K_INIT,          // power-up wait plus four instructions
    K_SCROLL_START,  // function set 1-line, cursor to column 7
    K_SCROLL_CHAR,   // data write, idle pause, shift left
    K_DATA_WRAP      // data write, cursor to row 1
  } kind_t;

  typedef enum logic [1:0] {
    EX_SLOW,
    EX_INSTR,
    EX_DATA
  } exec_t;

  typedef struct packed {
    kind_t      kind;
    logic       rs;
    logic [7:0] code;
    exec_t      exec;
  } plan_t;

  typedef struct packed {
    logic       rs;
    logic [7:0] data;
    logic       en;
    hold_t      hold;
    logic       last;
  } phase_t;

endpackage

// ===== hdl/lcd_seq_plan.sv =====
// Request decoder and text-mode state of the LCD sequencer.
module lcd_seq_plan #(
  parameter int DISPLAY_CHARS = lcd_seq_pkg::DISPLAY_CHARS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                req_fire,
  input  logic [3:0]          op,
  input  logic [2:0]          mode_bits,
  input  logic [7:0]          value,
  input  logic                row,
  input  logic [7:0]          text_length,
  output lcd_seq_pkg::plan_t  plan
);

  logic       scroll_mode_r, scroll_mode_nxt;
  logic       newline_seen_r, newline_seen_nxt;
  logic [7:0] text_index_r, text_index_nxt;
  logic [6:0] cursor_addr;
  logic       is_long;

  assign cursor_addr = value[6:0] + (row ? lcd_seq_pkg::ROW1_OFFSET : 7'd0);
  assign is_long     = {1'b0, text_length} > 9'(DISPLAY_CHARS);

  always_comb begin
    plan.kind = lcd_seq_pkg::K_WRITE;
    plan.rs   = 1'b0;
    plan.code = value;
    plan.exec = lcd_seq_pkg::EX_INSTR;
    scroll_mode_nxt  = scroll_mode_r;
    newline_seen_nxt = newline_seen_r;
    text_index_nxt   = text_index_r;
    unique case (lcd_seq_pkg::op_t'(op))
      lcd_seq_pkg::OP_INIT: plan.kind = lcd_seq_pkg::K_INIT;
      lcd_seq_pkg::OP_CLEAR: begin
        plan.code = lcd_seq_pkg::CMD_CLEAR;
        plan.exec = lcd_seq_pkg::EX_SLOW;
      end
      lcd_seq_pkg::OP_HOME: begin
        plan.code = lcd_seq_pkg::CMD_HOME;
        plan.exec = lcd_seq_pkg::EX_SLOW;
      end
      lcd_seq_pkg::OP_ENTRY:    plan.code = lcd_seq_pkg::CMD_ENTRY | {6'd0, mode_bits[1:0]};
      lcd_seq_pkg::OP_DISPLAY:  plan.code = lcd_seq_pkg::CMD_DISPLAY | {5'd0, mode_bits};
      lcd_seq_pkg::OP_SHIFT:
        plan.code = lcd_seq_pkg::CMD_SHIFT | {4'd0, mode_bits[1:0], 2'd0};
      lcd_seq_pkg::OP_FUNCTION:
        plan.code = lcd_seq_pkg::CMD_FUNCTION | {3'd0, mode_bits, 2'd0};
      lcd_seq_pkg::OP_CGRAM:    plan.code = lcd_seq_pkg::CMD_CGRAM | {2'd0, value[5:0]};
      lcd_seq_pkg::OP_DDRAM:    plan.code = lcd_seq_pkg::CMD_DDRAM | {1'b0, value[6:0]};
      lcd_seq_pkg::OP_CHAR: begin
        plan.rs   = 1'b1;
        plan.exec = lcd_seq_pkg::EX_DATA;
      end
      lcd_seq_pkg::OP_CURSOR:   plan.code = lcd_seq_pkg::CMD_DDRAM | {1'b0, cursor_addr};
      lcd_seq_pkg::OP_TEXT_START: begin
        text_index_nxt   = 8'd0;
        newline_seen_nxt = 1'b0;
        scroll_mode_nxt  = is_long;
        if (is_long) begin
          plan.kind = lcd_seq_pkg::K_SCROLL_START;
        end else begin
          plan.code = lcd_seq_pkg::CMD_FUNC_2LINE;
        end
      end
      lcd_seq_pkg::OP_TEXT_CHAR: begin
        priority if (scroll_mode_r) begin
          plan.kind = lcd_seq_pkg::K_SCROLL_CHAR;
          plan.rs   = 1'b1;
        end else if (value == lcd_seq_pkg::NEWLINE_CHAR) begin
          plan.code        = lcd_seq_pkg::CMD_CURSOR_ROW1;
          newline_seen_nxt = 1'b1;
        end else if (!newline_seen_r && text_index_r == lcd_seq_pkg::WRAP_INDEX) begin
          plan.kind = lcd_seq_pkg::K_DATA_WRAP;
          plan.rs   = 1'b1;
          plan.exec = lcd_seq_pkg::EX_DATA;
        end else begin
          plan.rs   = 1'b1;
          plan.exec = lcd_seq_pkg::EX_DATA;
        end
        if (text_index_r != 8'hFF) begin
          text_index_nxt = text_index_r + 8'd1;
        end
      end
      default: plan.kind = lcd_seq_pkg::K_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scroll_mode_r  <= 1'b0;
      newline_seen_r <= 1'b0;
      text_index_r   <= 8'd0;
    end else if (req_fire) begin
      scroll_mode_r  <= scroll_mode_nxt;
      newline_seen_r <= newline_seen_nxt;
      text_index_r   <= text_index_nxt;
    end
  end

endmodule

// ===== hdl/lcd_seq_phase.sv =====
// Phase generator: one bus phase from a decoded request and a phase index.
module lcd_seq_phase (
  input  lcd_seq_pkg::plan_t  plan,
  input  lcd_seq_pkg::idx_t   idx,
  input  lcd_seq_pkg::hold_t  delay_us,
  output lcd_seq_pkg::phase_t ph
);

  lcd_seq_pkg::hold_t exec_hold;

  always_comb begin
    unique case (plan.exec)
      lcd_seq_pkg::EX_SLOW: exec_hold = lcd_seq_pkg::T_SLOW;
      lcd_seq_pkg::EX_DATA: exec_hold = lcd_seq_pkg::T_DATA;
      default:              exec_hold = lcd_seq_pkg::T_INSTR;
    endcase
  end

  // Even index: enable high for 1 us; odd index: enable low for execution time, unless a kind overrides it.
  always_comb begin
    ph.rs   = plan.rs;
    ph.data = plan.code;
    ph.en   = ~idx[0];
    ph.hold = idx[0] ? exec_hold : lcd_seq_pkg::T_ENABLE;
    ph.last = 1'b0;
    unique case (plan.kind)
      lcd_seq_pkg::K_WRITE: ph.last = (idx == 4'd1);
      lcd_seq_pkg::K_INIT: begin
        // power-up wait shifts the pairs by one
        ph.rs   = 1'b0;
        ph.en   = idx[0];
        ph.hold = idx[0] ? lcd_seq_pkg::T_ENABLE : lcd_seq_pkg::T_INSTR;
        ph.last = (idx == 4'd8);
        unique case (idx)
          4'd0: begin
            ph.data = 8'd0;
            ph.hold = lcd_seq_pkg::T_POWERUP;
          end
          4'd1, 4'd2: ph.data = lcd_seq_pkg::CMD_FUNC_2LINE;
          4'd3, 4'd4: ph.data = lcd_seq_pkg::CMD_DISP_ON_CUR;
          4'd5, 4'd6: begin
            ph.data = lcd_seq_pkg::CMD_CLEAR;
            ph.hold = idx[0] ? lcd_seq_pkg::T_ENABLE : lcd_seq_pkg::T_SLOW;
          end
          default: ph.data = lcd_seq_pkg::CMD_ENTRY_INC;
        endcase
      end
      lcd_seq_pkg::K_SCROLL_START: begin
        ph.rs   = 1'b0;
        ph.data = idx[1] ? lcd_seq_pkg::CMD_CURSOR_MID : lcd_seq_pkg::CMD_FUNC_1LINE;
        ph.hold = idx[0] ? lcd_seq_pkg::T_INSTR : lcd_seq_pkg::T_ENABLE;
        ph.last = (idx == 4'd3);
      end
      lcd_seq_pkg::K_SCROLL_CHAR: begin
        ph.last = (idx == 4'd4);
        priority if (idx < 4'd2) begin
          ph.hold = idx[0] ? lcd_seq_pkg::T_DATA : lcd_seq_pkg::T_ENABLE;
        end else if (idx == 4'd2) begin
          ph.en   = 1'b0;
          ph.hold = delay_us;
        end else begin
          ph.rs   = 1'b0;
          ph.data = lcd_seq_pkg::CMD_SHIFT_LEFT;
          ph.en   = idx[0];
          ph.hold = idx[0] ? lcd_seq_pkg::T_ENABLE : lcd_seq_pkg::T_INSTR;
        end
      end
      lcd_seq_pkg::K_DATA_WRAP: begin
        ph.last = (idx == 4'd3);
        if (idx < 4'd2) begin
          ph.hold = idx[0] ? lcd_seq_pkg::T_DATA : lcd_seq_pkg::T_ENABLE;
        end else begin
          ph.rs   = 1'b0;
          ph.data = lcd_seq_pkg::CMD_CURSOR_ROW1;
          ph.hold = idx[0] ? lcd_seq_pkg::T_INSTR : lcd_seq_pkg::T_ENABLE;
        end
      end
      default: ph.last = 1'b1;
    endcase
  end

endmodule

// ===== hdl/char_lcd_command_text_sequencer_unit.sv =====
// Top level of the two-line character LCD command and text sequencer.
//
// Each request on the in_ channel (init, clear, home, entry mode, display
// control, shift, function set, CGRAM/DDRAM address, write char, set cursor,
// text start, text char) is expanded into timed bus phases on the out_
// channel: RS level, data byte, enable level and how many microseconds the
// phase is held. A bus write is an enable-high phase of 1 us followed by an
// enable-low phase held for the execution time. The last phase of each
// request carries out_last. A request has 9 phases for init, 5 for a
// scrolling text char, 4 for text start in scroll mode and for a wrapping
// text char, and 2 for everything else; the single phase generator loads
// the output register with one phase per cycle while out_ready does not
// stall it. The next request is taken in the cycle the current one's
// last phase is loaded, so requests stream with no gaps. Unused op codes
// (13 to 15) are accepted and produce nothing. cfg_data sets the pause
// after each scrolling text char in milliseconds (reset 500); write it
// only while no request is in flight. RW is not driven here: tie it low.
module char_lcd_command_text_sequencer_unit #(
  parameter int DISPLAY_CHARS = lcd_seq_pkg::DISPLAY_CHARS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_op,
  input  logic [2:0]  in_mode_bits,
  input  logic [7:0]  in_value,
  input  logic        in_row,
  input  logic [7:0]  in_text_length,
  // phase channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_reg_select,
  output logic [7:0]  out_bus_data,
  output logic        out_enable,
  output logic [25:0] out_hold_us,
  output logic        out_last,
  // scroll delay register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

`include "char_lcd_command_text_sequencer_unit_defines.svh"

  // Request register: decoded plan plus the index of the next phase to emit
  logic                a_vld_r;
  lcd_seq_pkg::plan_t  plan_r;
  lcd_seq_pkg::idx_t   idx_r;
  lcd_seq_pkg::plan_t  plan_nxt;
  lcd_seq_pkg::phase_t ph;

  // Scroll delay kept in microseconds, converted once per config write
  lcd_seq_pkg::hold_t  delay_us_r;
  lcd_seq_pkg::hold_t  delay_prod;

  // Output register
  logic                out_valid_r;
  logic                out_reg_select_r;
  logic [7:0]          out_bus_data_r;
  logic                out_enable_r;
  lcd_seq_pkg::hold_t  out_hold_us_r;
  logic                out_last_r;

  logic out_free;
  logic in_fire;

  assign out_free  = !out_valid_r || out_ready;
  // Free when empty, or when the last phase goes to the output this cycle
  assign in_ready  = !a_vld_r || (out_free && ph.last);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign delay_prod = lcd_seq_pkg::HOLD_W'(cfg_data) *
                      lcd_seq_pkg::HOLD_W'(lcd_seq_pkg::US_PER_MS);

  lcd_seq_plan #(
    .DISPLAY_CHARS (DISPLAY_CHARS)
  ) u_plan (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_fire    (in_fire),
    .op          (in_op),
    .mode_bits   (in_mode_bits),
    .value       (in_value),
    .row         (in_row),
    .text_length (in_text_length),
    .plan        (plan_nxt)
  );

  lcd_seq_phase u_phase (
    .plan     (plan_r),
    .idx      (idx_r),
    .delay_us (delay_us_r),
    .ph       (ph)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r     <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      delay_us_r  <= lcd_seq_pkg::HOLD_W'(lcd_seq_pkg::DELAY_RESET_MS * lcd_seq_pkg::US_PER_MS);
    end else begin
      if (cfg_valid) begin
        delay_us_r <= delay_prod;
      end
      if (out_free) begin
        out_valid_r <= a_vld_r;
      end
      if (in_fire) begin
        a_vld_r <= (plan_nxt.kind != lcd_seq_pkg::K_NONE);
        idx_r   <= '0;
      end else if (a_vld_r && out_free) begin
        if (ph.last) begin
          a_vld_r <= 1'b0;
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      plan_r <= plan_nxt;
    end
    if (out_free) begin
      out_reg_select_r <= ph.rs;
      out_bus_data_r   <= ph.data;
      out_enable_r     <= ph.en;
      out_hold_us_r    <= ph.hold;
      out_last_r       <= ph.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_reg_select = out_reg_select_r;
  assign out_bus_data   = out_bus_data_r;
  assign out_enable     = out_enable_r;
  assign out_hold_us    = out_hold_us_r;
  assign out_last       = out_last_r;

  // A request with phases starts at phase zero
  `LCD_SEQ_ASSERT_NEXT(a_load_idx0, in_fire && (plan_nxt.kind != lcd_seq_pkg::K_NONE), a_vld_r && (idx_r == 4'd0))
  // Phase index steps by one while a request is not finished
  `LCD_SEQ_ASSERT_NEXT(idx_step, !in_fire && a_vld_r && out_free && !ph.last, a_vld_r && (idx_r == $past(idx_r) + 4'd1))
  // Every enable-high phase is the 1 us strobe
  `LCD_SEQ_ASSERT(en_strobe, out_valid_r && out_enable_r, out_hold_us_r == lcd_seq_pkg::T_ENABLE)

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the character LCD command and text sequencer.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lcd_seq_pkg::*;

  localparam int DISP = DISPLAY_CHARS_DEF;
  // Op codes past the last defined one; the block takes them and emits nothing
  localparam logic [3:0] OP_FIRST_UNUSED = 4'(OP_TEXT_CHAR) + 4'd1;
  localparam logic [3:0] OP_LAST_UNUSED  = 4'hF;
  localparam int HOLDOFF   = 8;   // hold-off for unused ops, which emit no phases to wait for
  localparam int TAIL      = 20;
  localparam int MAX_SHOWN = 10;
  localparam int IDLE_PCT  = 8;

  // One host request, fields as on the in_ channel
  typedef struct packed {
    logic [3:0] op;
    logic [2:0] mode_bits;
    logic [7:0] value;
    logic       row;
    logic [7:0] text_length;
  } lcd_req_t;

  // Directed row: when typed is set, the phase count and the RS/byte of the
  // final phase are known by inspection and cross-checked
  typedef struct packed {
    lcd_req_t   req;
    logic       typed;
    logic [3:0] n_phases;
    logic       rs;
    logic [7:0] final_byte;
  } script_row_t;

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic [3:0]  in_op          = '0;
  logic [2:0]  in_mode_bits   = '0;
  logic [7:0]  in_value       = '0;
  logic        in_row         = 1'b0;
  logic [7:0]  in_text_length = '0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic        out_reg_select;
  logic [7:0]  out_bus_data;
  logic        out_enable;
  logic [25:0] out_hold_us;
  logic        out_last;
  logic        cfg_valid      = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data       = '0;

  char_lcd_command_text_sequencer_unit #(
    .DISPLAY_CHARS(DISP)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_mode_bits  (in_mode_bits),
    .in_value      (in_value),
    .in_row        (in_row),
    .in_text_length(in_text_length),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_reg_select(out_reg_select),
    .out_bus_data  (out_bus_data),
    .out_enable    (out_enable),
    .out_hold_us   (out_hold_us),
    .out_last      (out_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow of the sequencer: pause register and text state
  logic [15:0] pause_ms;
  logic        text_scroll;
  logic        seen_newline;
  logic [7:0]  char_pos;

  phase_t staged[$];          // phases of the request just taken
  phase_t awaited_phases[$];  // phases still owed by the block

  int  mismatch_count = 0;
  int  req_count      = 0;
  int  phase_count    = 0;
  int  text_blocks    = 0;
  int  setting_count  = 1;    // reset value counts as the first setting
  bit  steady         = 1'b0; // when set, neither side idles

  function automatic void report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_SHOWN) $display("MISMATCH: %s", msg);
  endfunction

  function automatic void add_phase(input logic rs, input logic [7:0] data, input logic en,
                                    input hold_t hold);
    phase_t p;
    p.rs   = rs;
    p.data = data;
    p.en   = en;
    p.hold = hold;
    p.last = 1'b0;
    staged.push_back(p);
  endfunction

  // A bus write: enable pulse of 1 us, then enable low for the execution time
  function automatic void add_write(input logic rs, input logic [7:0] data, input hold_t hold);
    add_phase(rs, data, 1'b1, T_ENABLE);
    add_phase(rs, data, 1'b0, hold);
  endfunction

  // DDRAM address for column/row; row 1 starts 40 in, wraps within 7 bits
  function automatic logic [7:0] cursor_code(input logic [7:0] col, input logic row);
    logic [7:0] sum;
    sum = col + (row ? 8'(ROW1_OFFSET) : 8'd0);
    return CMD_DDRAM | {1'b0, sum[6:0]};
  endfunction

  // Expands one accepted request into bus phases and advances the text state
  function automatic void expand_request(input lcd_req_t r);
    phase_t tail_phase;
    staged.delete();
    case (r.op)
      OP_INIT: begin
        add_phase(1'b0, 8'h00, 1'b0, T_POWERUP);
        add_write(1'b0, CMD_FUNC_2LINE, T_INSTR);
        add_write(1'b0, CMD_DISP_ON_CUR, T_INSTR);
        add_write(1'b0, CMD_CLEAR, T_SLOW);
        add_write(1'b0, CMD_ENTRY_INC, T_INSTR);
      end
      OP_CLEAR:    add_write(1'b0, CMD_CLEAR, T_SLOW);
      OP_HOME:     add_write(1'b0, CMD_HOME, T_SLOW);
      OP_ENTRY:    add_write(1'b0, CMD_ENTRY | {6'd0, r.mode_bits[1:0]}, T_INSTR);
      OP_DISPLAY:  add_write(1'b0, CMD_DISPLAY | {5'd0, r.mode_bits}, T_INSTR);
      OP_SHIFT:    add_write(1'b0, CMD_SHIFT | {4'd0, r.mode_bits[1:0], 2'd0}, T_INSTR);
      OP_FUNCTION: add_write(1'b0, CMD_FUNCTION | {3'd0, r.mode_bits, 2'd0}, T_INSTR);
      OP_CGRAM:    add_write(1'b0, CMD_CGRAM | {2'd0, r.value[5:0]}, T_INSTR);
      OP_DDRAM:    add_write(1'b0, CMD_DDRAM | {1'b0, r.value[6:0]}, T_INSTR);
      OP_CHAR:     add_write(1'b1, r.value, T_DATA);
      OP_CURSOR:   add_write(1'b0, cursor_code(r.value, r.row), T_INSTR);
      OP_TEXT_START: begin
        char_pos     = 8'd0;
        seen_newline = 1'b0;
        if (r.text_length > DISP) begin
          // long text: one-line mode, start mid-display and scroll
          text_scroll = 1'b1;
          add_write(1'b0, CMD_FUNC_1LINE, T_INSTR);
          add_write(1'b0, CMD_CURSOR_MID, T_INSTR);
        end else begin
          text_scroll = 1'b0;
          add_write(1'b0, CMD_FUNC_2LINE, T_INSTR);
        end
      end
      OP_TEXT_CHAR: begin
        if (text_scroll) begin
          // newline is an ordinary glyph here; pause keeps RS and byte
          add_write(1'b1, r.value, T_DATA);
          add_phase(1'b1, r.value, 1'b0, hold_t'(pause_ms * US_PER_MS));
          add_write(1'b0, CMD_SHIFT_LEFT, T_INSTR);
        end else if (r.value == NEWLINE_CHAR) begin
          add_write(1'b0, CMD_CURSOR_ROW1, T_INSTR);
          seen_newline = 1'b1;
        end else begin
          add_write(1'b1, r.value, T_DATA);
          // eighth glyph with no earlier newline wraps to row 1 once
          if (!seen_newline && char_pos == WRAP_INDEX)
            add_write(1'b0, CMD_CURSOR_ROW1, T_INSTR);
        end
        if (char_pos != 8'hFF) char_pos++;
      end
      default: ;
    endcase
    if (staged.size() > 0) begin
      tail_phase      = staged.pop_back();
      tail_phase.last = 1'b1;
      staged.push_back(tail_phase);
    end
    foreach (staged[i]) awaited_phases.push_back(staged[i]);
  endfunction

  function automatic lcd_req_t random_req(input logic [3:0] op);
    lcd_req_t r;
    r.op          = op;
    r.mode_bits   = 3'($urandom);
    r.value       = 8'($urandom);
    r.row         = 1'($urandom);
    r.text_length = 8'($urandom);
    return r;
  endfunction

  // Result side: ready drops at random, with probability IDLE_PCT percent, unless steady
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Every accepted phase is matched against the oldest owed one
  always @(posedge clk) begin : watch_phases
    phase_t want;
    if (rst_n && out_valid && out_ready) begin
      phase_count++;
      if (awaited_phases.size() == 0) begin
        report_mismatch($sformatf("unexpected phase rs=%0b data=%02h en=%0b hold=%0d last=%0b",
                                  out_reg_select, out_bus_data, out_enable, out_hold_us,
                                  out_last));
      end else begin
        want = awaited_phases.pop_front();
        if (out_reg_select !== want.rs || out_bus_data !== want.data ||
            out_enable !== want.en || out_hold_us !== want.hold || out_last !== want.last)
          report_mismatch($sformatf(
            "phase %0d exp rs=%0b data=%02h en=%0b hold=%0d last=%0b, got %0b %02h %0b %0d %0b",
            phase_count, want.rs, want.data, want.en, want.hold, want.last,
            out_reg_select, out_bus_data, out_enable, out_hold_us, out_last));
      end
    end
  end

  // Presents one request, possibly after idle cycles, and waits for the
  // handshake. Returns in the step of acceptance with valid still high, so
  // the caller must drive valid again in that same step without waiting.
  task automatic send_req(input lcd_req_t r);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_op          <= r.op;
    in_mode_bits   <= r.mode_bits;
    in_value       <= r.value;
    in_row         <= r.row;
    in_text_length <= r.text_length;
    do @(posedge clk); while (!in_ready);
    expand_request(r);
    if (r.op <= OP_TEXT_CHAR) req_count++;
  endtask

  // Stops requests and waits for every owed phase, plus a short hold-off
  // since an unused op may still occupy the block
  task automatic settle();
    in_valid <= 1'b0;
    while (awaited_phases.size() != 0) @(posedge clk);
    repeat (HOLDOFF) @(posedge clk);
  endtask

  task automatic write_pause(input logic [15:0] ms);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= ms;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pause_ms = ms;
    setting_count++;
  endtask

  // Mostly well-formed text blocks (start, then a run of chars), plus single
  // commands, unused ops and stray chars outside any announced text
  task automatic random_phase(input int n_items);
    int       stop_at;
    int       pick;
    int       n_chars;
    lcd_req_t r;
    stop_at = req_count + n_items;
    while (req_count < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        r = random_req(OP_TEXT_START);
        r.text_length = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(DISP + 1, 255))
                                                    : 8'($urandom_range(0, DISP));
        send_req(r);
        n_chars = (r.text_length > DISP) ? $urandom_range(1, 8)
                                         : $urandom_range(1, int'(r.text_length) + 2);
        text_blocks++;
        repeat (n_chars) begin
          r = random_req(OP_TEXT_CHAR);
          if ($urandom_range(0, 9) == 0) r.value = NEWLINE_CHAR;
          send_req(r);
        end
      end else if (pick < 90) begin
        send_req(random_req(4'($urandom_range(int'(OP_INIT), int'(OP_CURSOR)))));
      end else if (pick < 95) begin
        send_req(random_req(4'($urandom_range(int'(OP_FIRST_UNUSED), int'(OP_LAST_UNUSED)))));
      end else begin
        send_req(random_req(OP_TEXT_CHAR));
      end
    end
  endtask

  // Directed script: every op, field extremes, unused op, scroll entry and a
  // scrolled char, normal text up to the eighth-char wrap, then a newline
  script_row_t script [25] = '{
    '{'{OP_INIT,      3'd0, 8'h00, 1'b0, 8'd0}, 1'b1, 4'd9, 1'b0, CMD_ENTRY_INC},
    '{'{OP_CLEAR,     3'd7, 8'hFF, 1'b1, 8'hFF}, 1'b1, 4'd2, 1'b0, CMD_CLEAR},
    '{'{OP_HOME,      3'd0, 8'h00, 1'b0, 8'd0}, 1'b1, 4'd2, 1'b0, CMD_HOME},
    '{'{OP_ENTRY,     3'd7, 8'h00, 1'b0, 8'd0}, 1'b1, 4'd2, 1'b0, 8'h07},
    '{'{OP_DISPLAY,   3'd7, 8'h00, 1'b0, 8'd0}, 1'b1, 4'd2, 1'b0, 8'h0F},
    '{'{OP_SHIFT,     3'd7, 8'h00, 1'b0, 8'd0}, 1'b1, 4'd2, 1'b0, 8'h1C},
    '{'{OP_FUNCTION,  3'd7, 8'h00, 1'b0, 8'd0}, 1'b1, 4'd2, 1'b0, 8'h3C},
    '{'{OP_CGRAM,     3'd0, 8'hFF, 1'b0, 8'd0}, 1'b1, 4'd2, 1'b0, 8'h7F},
    '{'{OP_DDRAM,     3'd0, 8'hFF, 1'b0, 8'd0}, 1'b1, 4'd2, 1'b0, 8'hFF},
    '{'{OP_CHAR,      3'd0, 8'h00, 1'b0, 8'd0}, 1'b1, 4'd2, 1'b1, 8'h00},
    '{'{OP_CHAR,      3'd7, 8'hFF, 1'b1, 8'hFF}, 1'b1, 4'd2, 1'b1, 8'hFF},
    '{'{OP_CURSOR,    3'd0, 8'hFF, 1'b1, 8'd0}, 1'b1, 4'd2, 1'b0, 8'hA7},
    '{'{OP_FIRST_UNUSED, 3'd7, 8'hFF, 1'b1, 8'hFF}, 1'b1, 4'd0, 1'b0, 8'h00},
    '{'{OP_TEXT_START, 3'd0, 8'h00, 1'b0, 8'd255}, 1'b1, 4'd4, 1'b0, CMD_CURSOR_MID},
    '{'{OP_TEXT_CHAR, 3'd0, 8'h41, 1'b0, 8'd0}, 1'b1, 4'd5, 1'b0, CMD_SHIFT_LEFT},
    '{'{OP_TEXT_START, 3'd0, 8'h00, 1'b0, 8'(DISP)}, 1'b1, 4'd2, 1'b0, CMD_FUNC_2LINE},
    '{'{OP_TEXT_CHAR, 3'd0, 8'h30, 1'b0, 8'd0}, 1'b0, 4'd0, 1'b0, 8'h00},
    '{'{OP_TEXT_CHAR, 3'd0, 8'h31, 1'b0, 8'd0}, 1'b0, 4'd0, 1'b0, 8'h00},
    '{'{OP_TEXT_CHAR, 3'd0, 8'h32, 1'b0, 8'd0}, 1'b0, 4'd0, 1'b0, 8'h00},
    '{'{OP_TEXT_CHAR, 3'd0, 8'h33, 1'b0, 8'd0}, 1'b0, 4'd0, 1'b0, 8'h00},
    '{'{OP_TEXT_CHAR, 3'd0, 8'h34, 1'b0, 8'd0}, 1'b0, 4'd0, 1'b0, 8'h00},
    '{'{OP_TEXT_CHAR, 3'd0, 8'h35, 1'b0, 8'd0}, 1'b0, 4'd0, 1'b0, 8'h00},
    '{'{OP_TEXT_CHAR, 3'd0, 8'h36, 1'b0, 8'd0}, 1'b0, 4'd0, 1'b0, 8'h00},
    '{'{OP_TEXT_CHAR, 3'd0, 8'h37, 1'b0, 8'd0}, 1'b1, 4'd4, 1'b0, CMD_CURSOR_ROW1},
    '{'{OP_TEXT_CHAR, 3'd0, NEWLINE_CHAR, 1'b0, 8'd0}, 1'b1, 4'd2, 1'b0, CMD_CURSOR_ROW1}
  };

  initial begin : stimulus
    int directed_reqs;
    pause_ms     = 16'(DELAY_RESET_MS);
    text_scroll  = 1'b0;
    seen_newline = 1'b0;
    char_pos     = 8'd0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part runs at the reset pause value
    foreach (script[i]) begin
      send_req(script[i].req);
      if (script[i].typed &&
          (staged.size() != int'(script[i].n_phases) ||
           (script[i].n_phases != 0 &&
            (staged[$].rs != script[i].rs || staged[$].data != script[i].final_byte))))
        report_mismatch($sformatf("script row %0d: table %0d phases ending %0b/%02h, model %0d",
                                  i, script[i].n_phases, script[i].rs, script[i].final_byte,
                                  staged.size()));
    end
    directed_reqs = req_count;

    // Random part over several pause settings, both extremes included
    write_pause(16'hFFFF);
    random_phase(60);
    write_pause(16'h0000);
    steady = 1'b1;          // long stretch with no idling on either side
    random_phase(50);
    steady = 1'b0;
    write_pause(16'($urandom));
    random_phase(50);
    write_pause(16'(DELAY_RESET_MS));
    random_phase(45);

    settle();
    repeat (TAIL) @(posedge clk);

    $display("Covered %0d requests (%0d directed, %0d text blocks), %0d bus phases checked",
             req_count, directed_reqs, text_blocks, phase_count);
    $display("Scroll pause went through %0d settings; %0d mismatches found",
             setting_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (every phase stalled at the
  // result side, every request delayed at the request side)
  initial begin
    #2_000_000;
    $display("Timeout with %0d phases still owed", awaited_phases.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
